// File: rtl/alpha_recovery_from_black_white_pixels_defines.svh
// Assertion macros for the alpha recovery block.
`ifndef ALPHA_RECOVERY_FROM_BLACK_WHITE_PIXELS_DEFINES_SVH
`define ALPHA_RECOVERY_FROM_BLACK_WHITE_PIXELS_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define ARBW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define ARBW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/arbw_pkg.sv
// Shared types and constants for the alpha recovery block.
package arbw_pkg;

    localparam int unsigned CHANNELS    = 3;
    localparam int unsigned DIV_STEPS   = 16;
    localparam logic [7:0]  CHAN_MAX    = 8'd255;
    localparam logic [9:0]  RECIP_3     = 10'd683;  // ceil(2^11 / 3)
    localparam int unsigned RECIP_SHIFT = 11;

    // One color channel in flight through the divider chain.
    typedef struct packed {
        logic [7:0]  alpha;  // divisor
        logic [7:0]  rem;    // partial remainder
        logic [15:0] work;   // dividend bits shifting out, quotient bits shifting in
    } t_chan;

    typedef struct packed {
        t_chan [CHANNELS-1:0] chan;
        logic [7:0]           mean_alpha;
        logic                 brighter;
        logic                 identical;
        logic                 frame_end;
    } t_word;

    typedef logic [CHANNELS-1:0][7:0] t_rgb;

endpackage

// File: rtl/arbw_prep.sv
// Entry stage: channel alphas, dividends, mean alpha and frame flags.
module arbw_prep
    import arbw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_rgb  i_black,
    input  t_rgb  i_white,
    input  logic  i_frame_end,
    output logic  o_valid,
    output t_word o_word
);

    logic        r_valid;
    t_word       r_word;
    t_word       n_word;
    logic        r_seen_difference;
    logic        n_seen_difference;
    logic [9:0]  alpha_sum;
    logic [19:0] mean_prod;
    logic        differs;

    always_comb begin
        n_word    = '0;
        alpha_sum = '0;
        differs   = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            n_word.chan[c].alpha = 8'(CHAN_MAX - i_white[c] + i_black[c]);
            n_word.chan[c].rem   = '0;
            // black * 255 as a shift and subtract
            n_word.chan[c].work  = {i_black[c], 8'd0} - {8'd0, i_black[c]};
            alpha_sum = alpha_sum + {2'b00, n_word.chan[c].alpha};
            if (i_black[c] > i_white[c]) begin
                n_word.brighter = 1'b1;
            end
            if (i_black[c] != i_white[c]) begin
                differs = 1'b1;
            end
        end
        // floor(sum / 3) by reciprocal, exact for sums up to 765
        mean_prod         = {10'd0, alpha_sum} * {10'd0, RECIP_3};
        n_word.mean_alpha = mean_prod[RECIP_SHIFT +: 8];
        n_word.frame_end  = i_frame_end;
        n_seen_difference = r_seen_difference | differs;
        n_word.identical  = i_frame_end & ~n_seen_difference;
        if (i_frame_end) begin
            n_seen_difference = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid           <= 1'b0;
            r_seen_difference <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_seen_difference <= n_seen_difference;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: rtl/arbw_div_cell.sv
// One restoring division step for all three channels, registered.
module arbw_div_cell
    import arbw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_word i_word,
    output logic  o_valid,
    output t_word o_word
);

    logic                 r_valid;
    t_word                r_word;
    t_word                n_word;
    logic [CHANNELS-1:0][8:0] trial;
    logic [CHANNELS-1:0]      qbit;

    always_comb begin
        n_word = i_word;
        for (int c = 0; c < CHANNELS; c++) begin
            trial[c] = {i_word.chan[c].rem, i_word.chan[c].work[15]};
            qbit[c]  = (trial[c] >= {1'b0, i_word.chan[c].alpha});
            if (qbit[c]) begin
                n_word.chan[c].rem = 8'(trial[c] - {1'b0, i_word.chan[c].alpha});
            end else begin
                n_word.chan[c].rem = trial[c][7:0];
            end
            n_word.chan[c].work = {i_word.chan[c].work[14:0], qbit[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: rtl/alpha_recovery_from_black_white_pixels.sv
// Top level: difference-matting alpha recovery, one pixel word per step.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | sink      | i_in_valid / o_in_ready    | black/white RGB bytes, frame end
//  out     | source    | o_out_valid / i_out_ready  | RGB, alpha, error, identical, end
//  cfg     | sink      | i_cfg_we (no wait)         | i_cfg_data = background level
//
// Pipeline: a word passes through one entry stage, a chain of
// 16 divider cells (one quotient bit of black*255/alpha per cell) and the output
// register. The whole chain advances together, so one word enters per cycle unless the output stalls.
// Reset: synchronous, active low; clears all valid bits, the frame difference flag
// and sets the background level to 255. No clearing pass.
// Stalls: when a result sits in the output register and is not taken, the whole
// chain and the input hold; o_in_ready drops in that same cycle.
module alpha_recovery_from_black_white_pixels
    import arbw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    // input words
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_black_red,
    input  logic [7:0] i_black_green,
    input  logic [7:0] i_black_blue,
    input  logic [7:0] i_white_red,
    input  logic [7:0] i_white_green,
    input  logic [7:0] i_white_blue,
    input  logic       i_frame_end,
    // result words
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_alpha,
    output logic       o_brighter_error,
    output logic       o_identical_frame,
    output logic       o_frame_end_out
);

    // chain advances unless a finished word waits in the output register
    logic adv;

    logic [7:0] r_bg;

    t_rgb black;
    t_rgb white;

    // stage 0 is the entry stage, stage k is divider cell k
    logic  [DIV_STEPS:0] stage_valid;
    t_word [DIV_STEPS:0] stage_word;

    logic                     r_out_valid;
    logic [CHANNELS-1:0][7:0] r_out_rgb;
    logic [CHANNELS-1:0][7:0] n_out_rgb;
    logic [7:0]               r_out_alpha;
    logic                     r_out_brighter;
    logic                     r_out_identical;
    logic                     r_out_frame_end;

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;

    // channel 0 red, 1 green, 2 blue
    assign black = {i_black_blue, i_black_green, i_black_red};
    assign white = {i_white_blue, i_white_green, i_white_red};

    // background level register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg <= CHAN_MAX;
        end else if (i_cfg_we) begin
            r_bg <= i_cfg_data;
        end
    end

    arbw_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_valid    (i_in_valid),
        .i_black    (black),
        .i_white    (white),
        .i_frame_end(i_frame_end),
        .o_valid    (stage_valid[0]),
        .o_word     (stage_word[0])
    );

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
        arbw_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (adv),
            .i_valid(stage_valid[k]),
            .i_word (stage_word[k]),
            .o_valid(stage_valid[k+1]),
            .o_word (stage_word[k+1])
        );
    end

    // zero alpha takes the background level, otherwise low byte of the quotient
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (stage_word[DIV_STEPS].chan[c].alpha == 8'd0) begin
                n_out_rgb[c] = r_bg;
            end else begin
                n_out_rgb[c] = stage_word[DIV_STEPS].chan[c].work[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= stage_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_rgb       <= n_out_rgb;
            r_out_alpha     <= stage_word[DIV_STEPS].mean_alpha;
            r_out_brighter  <= stage_word[DIV_STEPS].brighter;
            r_out_identical <= stage_word[DIV_STEPS].identical;
            r_out_frame_end <= stage_word[DIV_STEPS].frame_end;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_red         = r_out_rgb[0];
    assign o_out_green       = r_out_rgb[1];
    assign o_out_blue        = r_out_rgb[2];
    assign o_out_alpha       = r_out_alpha;
    assign o_brighter_error  = r_out_brighter;
    assign o_identical_frame = r_out_identical;
    assign o_frame_end_out   = r_out_frame_end;

endmodule

// File: rtl/arbw_checker.sv
// Port-level checker for the alpha recovery block, with its bind.
`include "alpha_recovery_from_black_white_pixels_defines.svh"

module arbw_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_brighter_error,
    input logic o_identical_frame,
    input logic o_frame_end_out
);

    // a result that is not taken stays offered
    `ARBW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result word dropped while stalled")

    // an empty output register never blocks the input
    `ARBW_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready, "input stalled with empty output")

    // identical frame is only reported on the last word of a frame
    `ARBW_ASSERT_NOW(a_ident_on_end, i_clk, i_rst_n, o_out_valid && o_identical_frame, o_frame_end_out, "identical flag off frame end")

    // a pixel with black brighter than white differs, so the frame cannot be identical
    `ARBW_ASSERT_NOW(a_ident_no_err, i_clk, i_rst_n, o_out_valid && o_identical_frame, !o_brighter_error, "identical frame with brighter error")

endmodule

bind alpha_recovery_from_black_white_pixels arbw_checker u_arbw_checker (.*);

// File: verif/alpha_recovery_from_black_white_pixels_tb.sv
// Testbench for alpha_recovery_from_black_white_pixels: directed pixels, then random frames.
`timescale 1ns / 100ps

module alpha_recovery_from_black_white_pixels_tb
    import arbw_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int unsigned PHASE_WORDS  = 200;   // least number of random pixel words per background setting
    localparam int unsigned PHASES       = 4;
    localparam int unsigned TAIL_CYCLES  = 40;    // > pipeline depth of 18
    localparam int unsigned MAX_PRINTED  = 40;

    // One pixel word: [0] red, [1] green, [2] blue.
    typedef struct packed {
        t_rgb black;
        t_rgb white;
        logic frame_end;
    } t_pixel;

    typedef struct packed {
        t_rgb       colour;
        logic [7:0] alpha;
        logic       brighter;
        logic       identical;
        logic       frame_end;
    } t_rgba;

    // Directed row: inputs, then a typed-in result when typed is set.
    typedef struct packed {
        logic [7:0] b_r, b_g, b_b;
        logic [7:0] w_r, w_g, w_b;
        logic       fe;
        logic       typed;
        logic [7:0] x_r, x_g, x_b, x_a;
        logic       x_brt, x_ident, x_fe;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_black_red, i_black_green, i_black_blue;
    logic [7:0] i_white_red, i_white_green, i_white_blue;
    logic       i_frame_end;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_red, o_out_green, o_out_blue, o_out_alpha;
    logic       o_brighter_error;
    logic       o_identical_frame;
    logic       o_frame_end_out;

    // Sidecar that travels with the payload so the monitor knows a typed-in row.
    logic       row_typed;
    t_rgba      row_expect;

    // Predictor state: its own copy of the register and the frame flag.
    logic [7:0] background_copy;
    logic       frame_has_diff;

    t_rgba       expected_rgba[$];
    t_row        directed_rows [16];
    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned frames_closed;
    int unsigned identical_frames;
    int unsigned brighter_words;
    int unsigned settings_used;
    bit          in_lazy;

    alpha_recovery_from_black_white_pixels u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_black_red       (i_black_red),
        .i_black_green     (i_black_green),
        .i_black_blue      (i_black_blue),
        .i_white_red       (i_white_red),
        .i_white_green     (i_white_green),
        .i_white_blue      (i_white_blue),
        .i_frame_end       (i_frame_end),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_red         (o_out_red),
        .o_out_green       (o_out_green),
        .o_out_blue        (o_out_blue),
        .o_out_alpha       (o_out_alpha),
        .o_brighter_error  (o_brighter_error),
        .o_identical_frame (o_identical_frame),
        .o_frame_end_out   (o_frame_end_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d words still expected",
                 cycle_count, expected_rgba.size());
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: alpha per channel is 255 - white + black, wrapping at 8 bits.
    // Colour is black*255/alpha (low byte kept), or the background level when
    // alpha is zero. Updates the frame-difference flag as a side effect.
    // ------------------------------------------------------------------
    function automatic t_rgba recover_pixel(input t_pixel px);
        t_rgba       r;
        logic [7:0]  a;
        logic [15:0] quotient;
        logic [9:0]  alpha_sum;
        logic        differs;
        int          c;
        r         = '0;
        alpha_sum = '0;
        differs   = 1'b0;
        for (c = 0; c < 3; c++) begin
            a = CHAN_MAX - px.white[c] + px.black[c];
            alpha_sum = alpha_sum + 10'(a);
            if (px.black[c] > px.white[c]) begin
                r.brighter = 1'b1;
            end
            if (px.black[c] != px.white[c]) begin
                differs = 1'b1;
            end
            if (a == 8'd0) begin
                r.colour[c] = background_copy;
            end else begin
                quotient    = (16'(px.black[c]) * 16'(CHAN_MAX)) / 16'(a);
                r.colour[c] = quotient[7:0];
            end
        end
        r.alpha        = 8'(alpha_sum / 10'd3);
        frame_has_diff = frame_has_diff | differs;
        r.frame_end    = px.frame_end;
        if (px.frame_end) begin
            r.identical    = ~frame_has_diff;
            frame_has_diff = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED) begin
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("word %0d %s: got %0d, want %0d",
                                      words_checked, name, got, want));
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor. Samples pre-edge values at each rising edge: results first
    // (they are always older than anything accepted at the same edge),
    // then the accepted input word, which the predictor turns into an
    // expectation unless the row carries a typed-in one.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rgba  got, want, calc;
        t_pixel px;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.colour    = {o_out_blue, o_out_green, o_out_red};
                got.alpha     = o_out_alpha;
                got.brighter  = o_brighter_error;
                got.identical = o_identical_frame;
                got.frame_end = o_frame_end_out;
                if (expected_rgba.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing outstanding: %h", got));
                end else begin
                    want = expected_rgba.pop_front();
                    check_field("red",       got.colour[0], want.colour[0]);
                    check_field("green",     got.colour[1], want.colour[1]);
                    check_field("blue",      got.colour[2], want.colour[2]);
                    check_field("alpha",     got.alpha,     want.alpha);
                    check_field("brighter",  got.brighter,  want.brighter);
                    check_field("identical", got.identical, want.identical);
                    check_field("frame_end", got.frame_end, want.frame_end);
                end
                words_checked++;
                frames_closed    += got.frame_end;
                identical_frames += got.identical;
                brighter_words   += got.brighter;
            end
            if (i_in_valid && o_in_ready) begin
                px.black     = {i_black_blue, i_black_green, i_black_red};
                px.white     = {i_white_blue, i_white_green, i_white_red};
                px.frame_end = i_frame_end;
                calc = recover_pixel(px);
                expected_rgba.push_back(row_typed ? row_expect : calc);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: per word, hold ready low for a random gap, which may be none,
    // then high until a word is taken. Busy stretches (no stall at all) come and go.
    // ------------------------------------------------------------------
    initial begin
        int unsigned gap;
        int unsigned burst_left;
        bit          out_lazy;
        burst_left = 0;
        out_lazy   = 1'b1;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (burst_left == 0) begin
                out_lazy   = ($urandom_range(0, 3) != 0);
                burst_left = $urandom_range(10, 60);
            end
            burst_left--;
            gap = out_lazy ? $urandom_range(0, 15) : 0;
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Drives one word after a random gap; returns at the edge that takes it.
    // Valid stays high across back-to-back words (one assignment per step).
    task automatic send_pixel(input t_pixel px, input logic typed, input t_rgba want);
        int unsigned gap;
        gap = in_lazy ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_black_red   <= px.black[0];
        i_black_green <= px.black[1];
        i_black_blue  <= px.black[2];
        i_white_red   <= px.white[0];
        i_white_green <= px.white[1];
        i_white_blue  <= px.white[2];
        i_frame_end   <= px.frame_end;
        row_typed     <= typed;
        row_expect    <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Sender stops and waits for every outstanding result word.
    // It first lets the next edge pass so the word taken at the last edge is already queued.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_rgba.size() != 0) @(posedge i_clk);
    endtask

    // Only called with the pipe empty; the predictor copy follows the write.
    task automatic write_background(input logic [7:0] level);
        i_cfg_we        <= 1'b1;
        i_cfg_data      <= level;
        background_copy  = level;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Random channel mix: plain random, equal, zero alpha (black = white + 1),
    // rails only, and black brighter than white. A no-difference frame forces
    // black == white everywhere.
    function automatic t_pixel draw_pixel(input bit same_frame, input bit last);
        t_pixel px;
        int     c;
        int     mode;
        for (c = 0; c < 3; c++) begin
            mode        = $urandom_range(0, 8);
            px.white[c] = 8'($urandom_range(0, 255));
            px.black[c] = 8'($urandom_range(0, 255));
            if (same_frame || mode == 4) begin
                px.black[c] = px.white[c];
            end else if (mode == 5) begin
                px.black[c] = px.white[c] + 8'd1;
            end else if (mode == 6) begin
                px.black[c] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                px.white[c] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            end else if (mode >= 7) begin
                px.white[c] = 8'($urandom_range(0, 254));
                px.black[c] = 8'($urandom_range(int'(px.white[c]) + 1, 255));
            end
        end
        px.frame_end = last;
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        t_row        row;
        t_pixel      px;
        t_rgba       want;
        int unsigned k;
        int unsigned p;
        int unsigned sent;
        int unsigned frame_len;
        bit          same_frame;
        logic [7:0]  level;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_black_red     <= '0;
        i_black_green   <= '0;
        i_black_blue    <= '0;
        i_white_red     <= '0;
        i_white_green   <= '0;
        i_white_blue    <= '0;
        i_frame_end     <= 1'b0;
        i_out_ready     <= 1'b0;
        row_typed       <= 1'b0;
        row_expect      <= '0;
        background_copy  = CHAN_MAX;  // reset value of the register
        frame_has_diff   = 1'b0;
        mismatches       = 0;
        words_checked    = 0;
        frames_closed    = 0;
        identical_frames = 0;
        brighter_words   = 0;
        settings_used    = 0;
        in_lazy          = 1'b1;

        //                blk r  g  b   wht r  g  b  fe ty  exp r  g  b   a brt id fe
        directed_rows = '{
            // zero alpha everywhere: colour is the reset background level
            '{  0,   0,   0, 255, 255, 255, 0, 1, 255, 255, 255,   0, 0, 0, 0},
            // full-scale opaque and black opaque
            '{255, 255, 255, 255, 255, 255, 0, 1, 255, 255, 255, 255, 0, 0, 0},
            '{  0,   0,   0,   0,   0,   0, 0, 1,   0,   0,   0, 255, 0, 0, 0},
            // frame end after differing pixels: not identical
            '{  0,   0,   0,   0,   0,   0, 1, 1,   0,   0,   0, 255, 0, 0, 1},
            // one-pixel frame with black == white: identical
            '{128, 128, 128, 128, 128, 128, 1, 1, 128, 128, 128, 255, 0, 1, 1},
            // black brighter, alpha wraps to 254, quotient 256 keeps low byte
            '{255, 255, 255,   0,   0,   0, 0, 1,   0,   0,   0, 254, 1, 0, 0},
            // black brighter by one: alpha wraps to zero
            '{  1,   1,   1,   0,   0,   0, 0, 1, 255, 255, 255,   0, 1, 0, 0},
            '{200,  17, 255, 250,  17,   0, 1, 0,   0,   0,   0,   0, 0, 0, 0},
            // wrapped alpha below black: quotient above 255
            '{200, 100,   3, 100,  50,   2, 0, 0,   0,   0,   0,   0, 0, 0, 0},
            '{  0, 255,   1, 255,   0,   0, 0, 0,   0,   0,   0,   0, 0, 0, 0},
            '{255,   0, 128, 255,   0, 127, 0, 0,   0,   0,   0,   0, 0, 0, 0},
            '{  1, 254,  64,   1, 254,  64, 1, 0,   0,   0,   0,   0, 0, 0, 0},
            '{  7,   7,   7,   7,   7,   7, 1, 1,   7,   7,   7, 255, 0, 1, 1},
            '{ 85, 170,   1, 170,  85, 128, 0, 0,   0,   0,   0,   0, 0, 0, 0},
            '{254,   1, 127, 255,   2, 128, 1, 0,   0,   0,   0,   0, 0, 0, 0},
            // zero alpha on one channel only
            '{  0,   5,   9, 255,   5,   9, 1, 0,   0,   0,   0,   0, 0, 0, 0}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset background level.
        for (k = 0; k < $size(directed_rows); k++) begin
            row            = directed_rows[k];
            px.black       = {row.b_b, row.b_g, row.b_r};
            px.white       = {row.w_b, row.w_g, row.w_r};
            px.frame_end   = row.fe;
            want.colour    = {row.x_b, row.x_g, row.x_r};
            want.alpha     = row.x_a;
            want.brighter  = row.x_brt;
            want.identical = row.x_ident;
            want.frame_end = row.x_fe;
            send_pixel(px, row.typed, want);
        end

        // Random frames, one background setting per phase: zero, mid, full, any.
        for (p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: begin
                    level = 8'h00;
                end
                1: begin
                    level = 8'($urandom_range(1, 254));
                end
                2: begin
                    level = 8'hFF;
                end
                default: begin
                    level = 8'($urandom_range(0, 255));
                end
            endcase
            write_background(level);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                same_frame = ($urandom_range(0, 3) == 0);
                frame_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                         : $urandom_range(1, 8);
                in_lazy    = ($urandom_range(0, 3) != 0);
                for (k = 0; k < frame_len; k++) begin
                    send_pixel(draw_pixel(same_frame, k == frame_len - 1), 1'b0, '0);
                    sent++;
                end
                // occasional mid-phase drain between frames
                if ($urandom_range(0, 15) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_rgba.size() != 0) begin
            report_mismatch($sformatf("%0d result words never arrived", expected_rgba.size()));
        end

        $display("checked %0d result words over %0d frames, %0d of them with no difference",
                 words_checked, frames_closed, identical_frames);
        $display("%0d words flagged black brighter; %0d background settings; %0d mismatches",
                 brighter_words, settings_used + 1, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
